/* rtl/tscd_pkg.sv */
// tscd_pkg: constants, widths and q1.15 tables for the degree sine/cosine pipeline
// no dependencies; imported by table_sine_cosine_degrees_top and tscd_checker
`default_nettype none

package tscd_pkg;

   // field formats
   localparam int ANGLE_W         = 24;
   localparam int ANGLE_FRAC_BITS = 8;
   localparam int OUT_W           = 16;
   localparam int OUT_FRAC_BITS   = 15;
   localparam int OUT_SAT         = 32767;

   // angle landmarks in input units
   localparam int UNIT_ANG = 1 << ANGLE_FRAC_BITS;
   localparam int FULL_ANG = 360 * UNIT_ANG;
   localparam int HALF_ANG = 180 * UNIT_ANG;
   localparam int QUAR_ANG = 90 * UNIT_ANG;
   localparam int TEN_ANG  = 10 * UNIT_ANG;

   // full turn = 45 * 2^LOW_W, so the low bits pass and the rest is reduced mod 45
   localparam int MOD_DIV  = 45;
   localparam int SUM_W    = ANGLE_W + 1;
   localparam int LOW_W    = ANGLE_FRAC_BITS + 3;
   localparam int Q_W      = SUM_W - LOW_W;
   localparam int Q_OFS    = MOD_DIV * ((1 << (Q_W - 1)) / MOD_DIV + 1);
   localparam int X_W      = Q_W + 1;
   localparam int RECIP_SH = X_W + 2;
   localparam int RECIP    = (1 << RECIP_SH) / MOD_DIV;
   localparam int RECIP_W  = $clog2(RECIP + 1);
   localparam int PROD_W   = X_W + RECIP_W;
   localparam int QE_W     = PROD_W - RECIP_SH;
   localparam int RM_W     = $clog2(2 * MOD_DIV);
   localparam int WRAP_W   = $clog2(FULL_ANG);
   localparam int HALF_W   = $clog2(HALF_ANG);
   localparam int FOLD_W   = $clog2(QUAR_ANG + 1);
   localparam int IDX_W    = 4;
   localparam int B_W      = $clog2(TEN_ANG);
   localparam int FB_W     = B_W - ANGLE_FRAC_BITS;

   // product widths
   localparam int TAB_W    = 16;
   localparam int T1_W     = 2 * TAB_W;
   localparam int BS_W     = B_W + TAB_W;
   localparam int DEG_W    = 25;
   localparam logic [DEG_W-1:0] DEG_TO_RAD_Q30 = DEG_W'(18740330);
   localparam int T2F_W    = BS_W + DEG_W;
   localparam int T2_SH    = ANGLE_FRAC_BITS + 15;
   localparam int T2_W     = T2F_W - T2_SH;
   localparam int Y30_W    = 32;

   // final rounding from 30 fraction bits to the output format
   localparam int OUT_RSH  = (OUT_FRAC_BITS < 30) ? 30 - OUT_FRAC_BITS : 0;
   localparam int OUT_LSH  = (OUT_FRAC_BITS > 30) ? OUT_FRAC_BITS - 30 : 0;
   localparam int Y_W      = Y30_W + 2 + OUT_LSH;

   // sin(10a) in q1.15
   function automatic logic [TAB_W-1:0] sin10_q15(input logic [IDX_W-1:0] idx);
      logic [TAB_W-1:0] val;
      case (idx)
         4'd0:    val = 16'd0;
         4'd1:    val = 16'd5690;
         4'd2:    val = 16'd11207;
         4'd3:    val = 16'd16384;
         4'd4:    val = 16'd21063;
         4'd5:    val = 16'd25102;
         4'd6:    val = 16'd28378;
         4'd7:    val = 16'd30792;
         4'd8:    val = 16'd32270;
         4'd9:    val = 16'd32768;
         default: val = 16'd0;
      endcase
      return val;
   endfunction

   // cos(whole degrees) in q1.15
   function automatic logic [TAB_W-1:0] cos1_q15(input logic [IDX_W-1:0] idx);
      logic [TAB_W-1:0] val;
      case (idx)
         4'd0:    val = 16'd32768;
         4'd1:    val = 16'd32763;
         4'd2:    val = 16'd32748;
         4'd3:    val = 16'd32723;
         4'd4:    val = 16'd32688;
         4'd5:    val = 16'd32643;
         4'd6:    val = 16'd32588;
         4'd7:    val = 16'd32524;
         4'd8:    val = 16'd32449;
         4'd9:    val = 16'd32365;
         default: val = 16'd32768;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

/* rtl/table_sine_cosine_degrees_top.sv */
// table_sine_cosine_degrees_top: ten-stage pipeline for sine/cosine of an angle in degrees
// depends on tscd_pkg for widths, constants and the q1.15 tables
`default_nettype none

// channel   | dir | payload                                   | handshake
// ----------+-----+-------------------------------------------+----------------------
// req_      | in  | tdata[23:0] angle_in, tuser opcode        | req_tvalid/req_tready
// rsp_      | out | tdata[15:0] trig_out                      | rsp_tvalid/rsp_tready
//
// one item per cycle sustained while the output is not stalled; rsp_tvalid rises once
// the item has passed through every stage and sits in the output register
// the ten register stages are: quarter-turn add, mod-45 reciprocal multiply,
// remainder, fold, index split, table products, pi/180 multiply, correction rounding,
// sum, and output rounding with saturation and sign
// all stages advance together while the output register is empty or being taken;
// valid bits ride along with the data, so bubbles are carried and nothing is lost
// reset is synchronous and clears only the valid bits; the data registers need none

module table_sine_cosine_degrees_top (
   input  wire  logic                          clock,
   input  wire  logic                          reset,
   input  wire  logic                          req_tvalid,
   output       logic                          req_tready,
   input  wire  logic [tscd_pkg::ANGLE_W-1:0]  req_tdata,  // [23:0] angle_in
   input  wire  logic                          req_tuser,  // [0] opcode (1 = cosine)
   output       logic                          rsp_tvalid,
   input  wire  logic                          rsp_tready,
   output       logic [tscd_pkg::OUT_W-1:0]    rsp_tdata   // [15:0] trig_out
);

   import tscd_pkg::*;

   localparam int NSTG = 10;

   // global advance: the last stage is empty or its item leaves this cycle
   logic            adv;
   logic [NSTG-1:0] vld_ff;

   assign adv        = !vld_ff[NSTG-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[NSTG-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NSTG-2:0], req_tvalid};
      end
   end

   // ---------------- stage 1: add quarter turn for cosine, split off low bits
   logic signed [SUM_W-1:0] sum_in;
   logic        [Q_W-1:0]   q_in;
   logic        [X_W-1:0]   s1_x_ff;
   logic        [LOW_W-1:0] s1_low_ff;

   always_comb begin
      sum_in = $signed({req_tdata[ANGLE_W-1], req_tdata})
             + (req_tuser ? SUM_W'(QUAR_ANG) : SUM_W'(0));
      q_in   = sum_in[SUM_W-1:LOW_W];
   end

   // bias the signed count of 8-degree steps by a multiple of 45 so it is non-negative
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_x_ff   <= X_W'({q_in[Q_W-1], q_in}) + X_W'(Q_OFS);
         s1_low_ff <= sum_in[LOW_W-1:0];
      end
   end

   // ---------------- stage 2: reciprocal multiply for the quotient by 45
   logic [PROD_W-1:0] s2_prod_ff;
   logic [X_W-1:0]    s2_x_ff;
   logic [LOW_W-1:0]  s2_low_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_prod_ff <= PROD_W'(s1_x_ff) * PROD_W'(RECIP);
         s2_x_ff    <= s1_x_ff;
         s2_low_ff  <= s1_low_ff;
      end
   end

   // ---------------- stage 3: remainder mod 45 with one correction step
   // the quotient estimate is low by at most one, so the remainder is below 90
   logic [QE_W-1:0]   qe;
   logic [X_W-1:0]    rm_full;
   logic [RM_W-1:0]   rm;
   logic [RM_W-1:0]   rm_fix;
   logic [WRAP_W-1:0] s3_ang_ff;

   always_comb begin
      qe      = s2_prod_ff[PROD_W-1:RECIP_SH];
      rm_full = s2_x_ff - X_W'(qe) * X_W'(MOD_DIV);
      rm      = rm_full[RM_W-1:0];
      rm_fix  = (rm >= RM_W'(MOD_DIV)) ? rm - RM_W'(MOD_DIV) : rm;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_ang_ff <= {rm_fix[WRAP_W-LOW_W-1:0], s2_low_ff};
      end
   end

   // ---------------- stage 4: remove the lower half-turn, fold into 0..90
   logic [HALF_W-1:0] half_ang;
   logic              neg_in;
   logic [FOLD_W-1:0] s4_fold_ff;
   logic              s4_neg_ff;

   always_comb begin
      neg_in   = s3_ang_ff >= WRAP_W'(HALF_ANG);
      half_ang = neg_in ? HALF_W'(s3_ang_ff - WRAP_W'(HALF_ANG)) : HALF_W'(s3_ang_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_neg_ff  <= neg_in;
         s4_fold_ff <= (half_ang > HALF_W'(QUAR_ANG))
                       ? FOLD_W'(HALF_W'(HALF_ANG) - half_ang)
                       : FOLD_W'(half_ang);
      end
   end

   // ---------------- stage 5: ten-degree index and remainder
   // exactly 90 lands on index 9 with no remainder
   logic [IDX_W-1:0] a_in;
   logic [B_W-1:0]   b_in;
   logic [FB_W-1:0]  fb_raw;
   logic [IDX_W-1:0] s5_a_ff;
   logic [IDX_W-1:0] s5_fb_ff;
   logic [B_W-1:0]   s5_b_ff;
   logic             s5_neg_ff;

   always_comb begin
      a_in = '0;
      for (int i = 1; i <= 9; i++) begin
         if (s4_fold_ff >= FOLD_W'(i * TEN_ANG)) begin
            a_in = a_in + IDX_W'(1);
         end
      end
      b_in   = B_W'(s4_fold_ff - FOLD_W'(a_in) * FOLD_W'(TEN_ANG));
      fb_raw = b_in[B_W-1:ANGLE_FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_a_ff   <= a_in;
         s5_b_ff   <= b_in;
         s5_fb_ff  <= (fb_raw > FB_W'(9)) ? IDX_W'(9) : IDX_W'(fb_raw);
         s5_neg_ff <= s4_neg_ff;
      end
   end

   // ---------------- stage 6: sin(10a)*cos(floor b) and b*cos(10a)
   logic [T1_W-1:0] s6_t1_ff;
   logic [BS_W-1:0] s6_bs_ff;
   logic            s6_neg_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_t1_ff  <= T1_W'(sin10_q15(s5_a_ff)) * T1_W'(cos1_q15(s5_fb_ff));
         s6_bs_ff  <= BS_W'(s5_b_ff) * BS_W'(sin10_q15(IDX_W'(9) - s5_a_ff));
         s6_neg_ff <= s5_neg_ff;
      end
   end

   // ---------------- stage 7: scale the correction by pi/180
   logic [T1_W-1:0]  s7_t1_ff;
   logic [T2F_W-1:0] s7_t2f_ff;
   logic             s7_neg_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s7_t1_ff  <= s6_t1_ff;
         s7_t2f_ff <= T2F_W'(s6_bs_ff) * T2F_W'(DEG_TO_RAD_Q30);
         s7_neg_ff <= s6_neg_ff;
      end
   end

   // ---------------- stage 8: round the correction to 30 fraction bits
   logic [T2F_W-1:0] t2_rnd;
   logic [T1_W-1:0]  s8_t1_ff;
   logic [T2_W-1:0]  s8_t2_ff;
   logic             s8_neg_ff;

   assign t2_rnd = s7_t2f_ff + (T2F_W'(1) << (T2_SH - 1));

   always_ff @(posedge clock) begin
      if (adv) begin
         s8_t1_ff  <= s7_t1_ff;
         s8_t2_ff  <= t2_rnd[T2F_W-1:T2_SH];
         s8_neg_ff <= s7_neg_ff;
      end
   end

   // ---------------- stage 9: sum of both terms
   logic [Y30_W-1:0] s9_y30_ff;
   logic             s9_neg_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s9_y30_ff <= Y30_W'(s8_t1_ff) + Y30_W'(s8_t2_ff);
         s9_neg_ff <= s8_neg_ff;
      end
   end

   // ---------------- stage 10: round to output format, saturate, apply sign
   logic [Y_W-1:0]   y_rnd;
   logic [Y_W-1:0]   y_scl;
   logic [OUT_W-1:0] y_sat;
   logic [OUT_W-1:0] out_ff;

   always_comb begin
      y_rnd = Y_W'(s9_y30_ff) + Y_W'((1 << OUT_RSH) >> 1);
      y_scl = (y_rnd >> OUT_RSH) << OUT_LSH;
      y_sat = (y_scl > Y_W'(OUT_SAT)) ? OUT_W'(OUT_SAT) : OUT_W'(y_scl);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= s9_neg_ff ? OUT_W'(0) - y_sat : y_sat;
      end
   end

   assign rsp_tdata = out_ff;

endmodule

`default_nettype wire

/* rtl/tscd_checker.sv */
// tscd_checker: port-level checks on the sine/cosine pipeline, bound to the top level
// depends on tscd_pkg for port widths
`default_nettype none

module tscd_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_tvalid,
   input wire logic                          req_tready,
   input wire logic [tscd_pkg::ANGLE_W-1:0]  req_tdata,
   input wire logic                          req_tuser,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [tscd_pkg::OUT_W-1:0]    rsp_tdata
);

   import tscd_pkg::*;

   // a stalled result item holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp item changed or dropped");

   // no result item right after reset
   a_rst_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

   // an empty output stage always lets the pipeline move
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid || rsp_tready |-> req_tready)
      else $error("pipeline stalled with room at the output");

   // saturation keeps the result inside plus or minus full scale
   a_no_minneg: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata != {1'b1, {(OUT_W-1){1'b0}}})
      else $error("result outside saturation range");

   // a stall at the output blocks new items
   a_stall_block: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("item accepted into a stalled pipeline");

endmodule

bind table_sine_cosine_degrees_top tscd_checker u_tscd_checker (.*);

`default_nettype wire

/* bench/tscd_trig_checker.sv */
// tscd_trig_checker: opcode type shared by the bench, and a checker that predicts
// and compares every sine/cosine result; depends on tscd_pkg for field formats
`timescale 1ns / 1ps

package tscd_tb_pkg;
   typedef enum logic {OP_SINE = 1'b0, OP_COSINE = 1'b1} trig_op_type;
endpackage

module tscd_trig_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [tscd_pkg::ANGLE_W-1:0]  req_tdata,   // [23:0] angle_in
   input  logic                          req_tuser,   // [0] opcode
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [tscd_pkg::OUT_W-1:0]    rsp_tdata,   // [15:0] trig_out
   output int                            mismatch_count,
   output int                            awaiting,
   output int                            compared
);

   import tscd_tb_pkg::*;

   localparam int FRAC      = tscd_pkg::ANGLE_FRAC_BITS;
   localparam int DEG_ONE   = 1 << FRAC;
   localparam int TURN      = 360 * DEG_ONE;
   localparam int HALF_TURN = 180 * DEG_ONE;
   localparam int QUARTER   = 90 * DEG_ONE;
   localparam int TEN_DEG   = 10 * DEG_ONE;
   localparam longint unsigned PI_OVER_180_Q30 = 64'd18740330;
   localparam int CORR_SH   = FRAC + 15;
   localparam int OUT_SH    = 30 - tscd_pkg::OUT_FRAC_BITS;
   localparam longint unsigned MAG_SAT = 64'd32767;

   typedef struct {
      logic [tscd_pkg::ANGLE_W-1:0] angle;
      trig_op_type                  op;
      logic [tscd_pkg::OUT_W-1:0]   trig;
   } trig_expect_type;

   // q1.15 sin of whole tens of degrees, cos of whole degrees
   longint unsigned sin_tens [10] = '{0, 5690, 11207, 16384, 21063,
                                      25102, 28378, 30792, 32270, 32768};
   longint unsigned cos_ones [10] = '{32768, 32763, 32748, 32723, 32688,
                                      32643, 32588, 32524, 32449, 32365};

   trig_expect_type trig_expected [$];
   trig_expect_type oldest;

   function automatic logic [tscd_pkg::OUT_W-1:0] predict_trig(
      input logic [tscd_pkg::ANGLE_W-1:0] angle_raw,
      input trig_op_type                  op
   );
      int              deg;
      bit              lower_half;
      int              seg;
      int              rem;
      int              whole;
      longint unsigned prod_tab;
      longint unsigned corr;
      longint unsigned mag;
      deg = {{(32 - tscd_pkg::ANGLE_W){angle_raw[tscd_pkg::ANGLE_W-1]}}, angle_raw};
      if (op == OP_COSINE)
         deg = deg + QUARTER;
      // true modulo into one turn
      deg = deg % TURN;
      if (deg < 0)
         deg = deg + TURN;
      lower_half = (deg >= HALF_TURN);
      if (lower_half)
         deg = deg - HALF_TURN;
      // fold into 0..90, exactly 90 stays put
      if (deg > QUARTER)
         deg = HALF_TURN - deg;
      seg = deg / TEN_DEG;
      if (seg > 9)
         seg = 9;
      rem = deg - seg * TEN_DEG;
      whole = rem >> FRAC;
      if (whole > 9)
         whole = 9;
      prod_tab = sin_tens[seg] * cos_ones[whole];
      // linear correction: b * pi/180 * cos(10a), rounded half up to 30 fraction bits
      corr = longint'(rem) * PI_OVER_180_Q30 * sin_tens[9 - seg];
      corr = (corr + (64'd1 << (CORR_SH - 1))) >> CORR_SH;
      mag = ((prod_tab + corr) + (64'd1 << (OUT_SH - 1))) >> OUT_SH;
      if (mag > MAG_SAT)
         mag = MAG_SAT;
      if (lower_half)
         mag = -mag;
      return mag[tscd_pkg::OUT_W-1:0];
   endfunction

   // results are checked before the same edge's input is queued
   always @(posedge clock) begin
      if (reset) begin
         trig_expected.delete();
         mismatch_count = 0;
         awaiting       = 0;
         compared       = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (trig_expected.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               $display("%0t unexpected result: expected none actual %0d",
                        $time, $signed(rsp_tdata));
            end else begin
               oldest = trig_expected.pop_front();
               compared = compared + 1;
               if (rsp_tdata !== oldest.trig) begin
                  mismatch_count = mismatch_count + 1;
                  $display("%0t trig_out mismatch (angle %0d op %0d): expected %0d actual %0d",
                           $time, $signed(oldest.angle), oldest.op,
                           $signed(oldest.trig), $signed(rsp_tdata));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            oldest.angle = req_tdata;
            oldest.op    = trig_op_type'(req_tuser);
            oldest.trig  = predict_trig(req_tdata, trig_op_type'(req_tuser));
            trig_expected.push_back(oldest);
         end
         awaiting = trig_expected.size();
      end
   end

endmodule

/* bench/tb_table_sine_cosine_degrees_top.sv */
// tb_table_sine_cosine_degrees_top: stimulus and verdict for the degree sine/cosine block
// depends on tscd_pkg, tscd_tb_pkg and tscd_trig_checker, which predicts and compares
`timescale 1ns / 1ps

module tb_table_sine_cosine_degrees_top;
   import tscd_tb_pkg::*;

   localparam int RANDOM_ITEMS = 500;
   localparam int CALM_ITEMS   = 60;    // tail of the run with no idling on either side
   localparam int DEG_ONE      = 1 << tscd_pkg::ANGLE_FRAC_BITS;
   localparam int TWO_TURNS    = 720 * DEG_ONE;

   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [tscd_pkg::ANGLE_W-1:0]  req_tdata  = '0;   // [23:0] angle_in
   logic                          req_tuser  = 1'b0; // [0] opcode
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [tscd_pkg::OUT_W-1:0]    rsp_tdata;         // [15:0] trig_out

   // acceptance seen at the last rising edge, read back at the falling edge
   logic req_taken = 1'b0;
   // set for the tail of the run: both sides stop idling
   bit   calm = 1'b0;

   int   mismatch_count;
   int   awaiting;
   int   compared;
   int   sine_items   = 0;
   int   cosine_items = 0;

   always #5 clock = ~clock;

   table_sine_cosine_degrees_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   tscd_trig_checker i_trig_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .awaiting       (awaiting),
      .compared       (compared)
   );

   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
      end
   end

   // present one item from a falling edge and hold it until it is taken
   task automatic push_angle(input int ang, input trig_op_type op);
      req_tvalid <= 1'b1;
      req_tdata  <= ang[tscd_pkg::ANGLE_W-1:0];
      req_tuser  <= op;
      if (op == OP_COSINE)
         cosine_items++;
      else
         sine_items++;
      do @(negedge clock); while (!req_taken);
   endtask

   // receiver: random stall bursts, long ready stretches, none once calm
   initial begin : rsp_stalls
      int span;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 3) == 0) begin
            span = $urandom_range(1, 18);
            rsp_tready <= 1'b0;
         end else begin
            span = $urandom_range(1, 30);
            rsp_tready <= 1'b1;
         end
         // a burst in progress ends as soon as the calm tail starts
         for (int k = 1; k < span && !calm; k++) @(negedge clock);
      end
   end

   initial begin : stimulus
      int ang;
      int n;
      trig_op_type op;

      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: zero, quadrant edges, fold point at 90, half-turn sign change,
      // saturation at exactly 90, zero in the lower half-turn, field extremes
      push_angle(0, OP_SINE);
      push_angle(0, OP_COSINE);
      push_angle(90 * DEG_ONE, OP_SINE);        // a = 9, b = 0, saturates
      push_angle(90 * DEG_ONE, OP_COSINE);      // 180 degrees, negated zero
      push_angle(180 * DEG_ONE, OP_SINE);
      push_angle(270 * DEG_ONE, OP_SINE);       // most negative result
      push_angle(-90 * DEG_ONE, OP_SINE);
      push_angle(360 * DEG_ONE, OP_SINE);
      push_angle(32'h007F_FFFF, OP_SINE);       // largest positive angle
      push_angle(-32'sh0080_0000, OP_SINE);     // most negative angle
      push_angle(32'h007F_FFFF, OP_COSINE);
      push_angle(-32'sh0080_0000, OP_COSINE);
      push_angle(1, OP_SINE);
      push_angle(-1, OP_SINE);
      push_angle(10 * DEG_ONE - 1, OP_SINE);    // remainder just under ten
      push_angle(10 * DEG_ONE, OP_SINE);
      push_angle(90 * DEG_ONE - 1, OP_SINE);    // a = 8 top end, saturates
      push_angle(90 * DEG_ONE + 1, OP_SINE);    // just past the fold
      push_angle(180 * DEG_ONE - 1, OP_SINE);
      push_angle(180 * DEG_ONE + 1, OP_SINE);
      push_angle(-1, OP_COSINE);
      push_angle(70 * DEG_ONE, OP_COSINE);
      push_angle(30 * DEG_ONE - 1, OP_COSINE);

      // random: mostly angles within two turns, some near the 5-degree landmarks,
      // some over the whole 24-bit field
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS - CALM_ITEMS)
            calm = 1'b1;
         // drain pause midway: hold off until every result is back
         if (i == RANDOM_ITEMS / 2) begin
            req_tvalid <= 1'b0;
            do @(negedge clock); while (awaiting != 0);
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 18);
            req_tvalid <= 1'b0;
            repeat (n) @(negedge clock);
         end
         case ($urandom_range(0, 9))
            0, 1: ang = int'($urandom);
            2, 3, 4: ang = (int'($urandom_range(0, 144)) - 72) * 5 * DEG_ONE
                           + int'($urandom_range(0, 6)) - 3;
            default: ang = int'($urandom_range(0, 2 * TWO_TURNS)) - TWO_TURNS;
         endcase
         op = trig_op_type'($urandom_range(0, 1));
         push_angle(ang, op);
      end
      req_tvalid <= 1'b0;

      // everything in flight comes back, then the bench idles before the verdict
      do @(negedge clock); while (awaiting != 0);
      repeat (30) @(negedge clock);

      $display("covered %0d angles (%0d sine, %0d cosine), %0d results compared, %0d mismatches",
               sine_items + cosine_items, sine_items, cosine_items, compared, mismatch_count);
      $display("angles spanned the full 24-bit field with stalls on both channels and a drain");
      if (mismatch_count == 0 && awaiting == 0) begin
         $display("table_sine_cosine_degrees_top test passed");
      end else begin
         $display("table_sine_cosine_degrees_top test failed");
      end
      $finish;
   end

   // hang guard, far above the slowest legal run
   initial begin : watchdog
      #2000000;
      $display("timeout with %0d results outstanding", awaiting);
      $display("table_sine_cosine_degrees_top test failed");
      $finish;
   end

endmodule
